FILE: src/fdu_pkg.sv
// fdu_pkg: shared types, constants and the arctangent table of the fisheye
// distort/undistort block. No dependencies.
`timescale 1ns / 1ps
package fdu_pkg;

  // fixed point format of coordinates and coefficients
  localparam int FRAC_BITS = 24;
  // coefficient registers k1..k5
  localparam int NUM_K = 5;
  localparam int CORDIC_STEPS = 31;
  // table angles are in q30
  localparam int ANGLE_FRAC = 30;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_K1           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K2           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_K3           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_K4           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_K5           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESH  = 3'd6;

  localparam logic CMD_DISTORT   = 1'b0;
  localparam logic CMD_UNDISTORT = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DIVERGED = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic               status;
  } out_t;

  // atan(2^-i) in q30
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      5'd24: v = 32'd63;
      5'd25: v = 32'd31;
      5'd26: v = 32'd15;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/fdu_mul.sv
// fdu_mul: shared 64x64 magnitude multiplier, one 32x32 partial product a cycle,
// with an addend and a rounded, saturated fixed point result. Uses fdu_pkg.
`timescale 1ns / 1ps
module fdu_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  input  logic [63:0]        add_i,
  output logic               done_o,
  output logic [127:0]       prod_o,
  output logic               neg_o,
  output logic signed [63:0] mulq_o
);
  import fdu_pkg::*;

  localparam logic [63:0] MAG_LIMIT = 64'(1) << 62;

  logic [63:0]  am_q, bm_q;
  logic [127:0] acc_q;
  logic [63:0]  pp_q;
  logic [2:0]   step_q;
  logic         busy_q, done_q, neg_q;
  logic [31:0]  a_part, b_part;
  logic [127:0] pp_sh;
  logic [63:0]  m_raw, m_sat;

  // operand halves for the current partial product
  assign a_part = step_q[1] ? am_q[63:32] : am_q[31:0];
  assign b_part = step_q[0] ? bm_q[63:32] : bm_q[31:0];

  // weight of the partial product taken in the previous cycle
  always_comb begin
    case (step_q) inside
      3'd1:       pp_sh = {64'b0, pp_q};
      3'd2, 3'd3: pp_sh = {64'b0, pp_q} << 32;
      default:    pp_sh = {64'b0, pp_q} << 64;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      am_q  <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      bm_q  <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      acc_q <= {64'b0, add_i};
      neg_q <= a_i[63] ^ b_i[63];
    end else if (busy_q) begin
      if (step_q != 3'd4) pp_q <= a_part * b_part;
      if (step_q != 3'd0) acc_q <= acc_q + pp_sh;
    end
  end

  // rounded fixed point product, saturated at 2^62
  always_comb begin
    m_raw = acc_q[63+FRAC_BITS:FRAC_BITS];
    if (|acc_q[127:64+FRAC_BITS]) m_sat = MAG_LIMIT;
    else if (m_raw > MAG_LIMIT)   m_sat = MAG_LIMIT;
    else                          m_sat = m_raw;
  end

  assign mulq_o = neg_q ? -$signed(m_sat) : $signed(m_sat);
  assign prod_o = acc_q;
  assign neg_o  = neg_q;
  assign done_o = done_q;

endmodule

FILE: src/fdu_sqrt.sv
// fdu_sqrt: bit-serial integer square root of a 64-bit value, two bits of the
// radicand a cycle. Uses fdu_pkg.
`timescale 1ns / 1ps
module fdu_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] n_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import fdu_pkg::*;

  logic [63:0] n_q, res_q, bit_q, trial;
  logic        busy_q, done_q, ge;

  assign trial = res_q + bit_q;
  assign ge    = (n_q >= trial);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // one restoring step a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= n_i;
      res_q <= '0;
      bit_q <= 64'(1) << 62;
    end else if (busy_q) begin
      if (ge) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o = res_q[31:0];
  assign done_o = done_q;

endmodule

FILE: src/fdu_atan.sv
// fdu_atan: cordic vectoring of (1, r) giving atan(r), one rotation a cycle.
// Uses the angle table and constants of fdu_pkg.
`timescale 1ns / 1ps
module fdu_atan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        r_i,
  output logic               done_o,
  output logic signed [31:0] theta_o
);
  import fdu_pkg::*;

  localparam int ASH = ANGLE_FRAC - FRAC_BITS;
  localparam logic signed [33:0] ROUND = (ASH == 0) ? 34'sd0 : (34'sd1 <<< (ASH - 1));

  logic signed [35:0] cx_q, cy_q, sx, sy;
  logic signed [33:0] z_q, ang, z_rnd;
  logic [4:0]         i_q;
  logic               busy_q, done_q;

  assign sx  = cx_q >>> i_q;
  assign sy  = cy_q >>> i_q;
  assign ang = $signed({2'b00, atan_lut(i_q)});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 5'd1;
        if (i_q == 5'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // rotate towards the x axis
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cx_q <= 36'sd1 <<< FRAC_BITS;
      cy_q <= $signed({4'b0, r_i});
      z_q  <= '0;
    end else if (busy_q) begin
      if (!cy_q[35]) begin
        cx_q <= cx_q + sy;
        cy_q <= cy_q - sx;
        z_q  <= z_q + ang;
      end else begin
        cx_q <= cx_q - sy;
        cy_q <= cy_q + sx;
        z_q  <= z_q - ang;
      end
    end
  end

  // angle back to the coordinate format, half up
  assign z_rnd   = (z_q + ROUND) >>> ASH;
  assign theta_o = z_rnd[31:0];
  assign done_o  = done_q;

endmodule

FILE: src/fdu_div.sv
// fdu_div: restoring divider, 128-bit dividend by 32-bit divisor, one quotient
// bit a cycle, quotient kept to 41 bits with an overflow flag. Uses fdu_pkg.
`timescale 1ns / 1ps
module fdu_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] num_i,
  input  logic [31:0]  den_i,
  output logic         done_o,
  output logic [40:0]  quo_o,
  output logic         big_o
);
  import fdu_pkg::*;

  logic [127:0] num_q;
  logic [31:0]  den_q, rem_q;
  logic [40:0]  q_q;
  logic         big_q, busy_q, done_q, ge;
  logic [6:0]   cnt_q;
  logic [32:0]  rem_sh, rem_n;

  assign rem_sh = {rem_q, num_q[127]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign rem_n  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit a cycle, msb first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      q_q   <= '0;
      big_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= rem_n[31:0];
      if (q_q[40]) big_q <= 1'b1;
      else         q_q   <= {q_q[39:0], ge};
    end
  end

  assign quo_o  = q_q;
  assign big_o  = big_q;
  assign done_o = done_q;

endmodule

FILE: src/fisheye_distort_undistort.sv
// Fisheye distortion (Kannala-Brandt) and its fixed point inversion.
// Depends on fdu_pkg, fdu_mul, fdu_sqrt, fdu_atan and fdu_div.
//
// One point at a time. A distort transfer runs the square root, the cordic
// arctangent, 15 multiplies on the shared multiplier and two serial divides
// that scale x and y. A zero radius skips the square root, the arctangent and
// the rest of the distortion. Undistort first squares the threshold once on the
// multiplier, then runs up to min(max_iterations, MAX_ITER_BOUND) distortions,
// with a step length test after each when the step fits in 32 bits, stopping
// early on convergence or divergence. The input stalls while a point is in
// work; a finished result waits in the output register while the next point
// is taken.
`timescale 1ns / 1ps
module fisheye_distort_undistort #(
  parameter int MAX_ITER_BOUND = 32,
  parameter int NUM_COEFFS     = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  fdu_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output fdu_pkg::out_t                    out_data_o,
  input  logic                             cfg_we_i,
  input  logic [fdu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [31:0]                      cfg_wdata_i
);
  import fdu_pkg::*;

  localparam int NK  = (NUM_COEFFS < NUM_K) ? NUM_COEFFS : NUM_K;
  localparam int ITW = $clog2(MAX_ITER_BOUND + 1);
  localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_THR   = 5'd1;
  localparam logic [4:0] S_R2A   = 5'd2;
  localparam logic [4:0] S_R2B   = 5'd3;
  localparam logic [4:0] S_SQRT  = 5'd4;
  localparam logic [4:0] S_ATAN  = 5'd5;
  localparam logic [4:0] S_T2    = 5'd6;
  localparam logic [4:0] S_KMUL  = 5'd7;
  localparam logic [4:0] S_TPMUL = 5'd8;
  localparam logic [4:0] S_TD    = 5'd9;
  localparam logic [4:0] S_SCX   = 5'd10;
  localparam logic [4:0] S_DIVX  = 5'd11;
  localparam logic [4:0] S_SCY   = 5'd12;
  localparam logic [4:0] S_DIVY  = 5'd13;
  localparam logic [4:0] S_DRET  = 5'd14;
  localparam logic [4:0] S_FX2   = 5'd15;
  localparam logic [4:0] S_FY2   = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  // configuration
  logic signed [31:0] coeff_q [NUM_K];
  logic [5:0]         max_iter_q;
  logic [30:0]        step_thr_q;

  // sequencer state
  logic [4:0]         state_q, state_d;
  logic               go_q, go_d;
  logic               cmd_q, cmd_d;
  logic signed [31:0] dx_q, dx_d, dy_q, dy_d, ox_q, ox_d, oy_q, oy_d;
  logic signed [31:0] px_q, px_d, py_q, py_d;
  logic               sat_q, sat_d, neg_q, neg_d;
  logic [63:0]        r2_q, r2_d, thr2_q, thr2_d, fsq_q, fsq_d;
  logic [31:0]        r_q, r_d;
  logic signed [31:0] theta_q, theta_d;
  logic signed [63:0] t2_q, t2_d, tp_q, tp_d, poly_q, poly_d, td_q, td_d;
  logic [2:0]         k_q, k_d;
  logic signed [33:0] fx_q, fx_d, fy_q, fy_d;
  logic [ITW-1:0]     it_q, it_d, n_q, n_d;
  out_t               res_q, res_d, out_q;
  logic               out_valid_q;

  // shared units
  logic               mul_start, mul_done, mul_neg;
  logic signed [63:0] mul_a, mul_b, mulq;
  logic [63:0]        mul_add;
  logic [127:0]       mul_prod;
  logic               sqrt_start, sqrt_done;
  logic [31:0]        sqrt_root;
  logic               atan_start, atan_done;
  logic signed [31:0] atan_theta;
  logic               div_start, div_done, div_big;
  logic [40:0]        div_quo;

  // combinational helpers
  logic               in_acc, out_load;
  logic signed [33:0] fx_c, fy_c, gx_c, gy_c;
  logic               gx_ok, gy_ok, fx_small, fy_small;
  logic signed [31:0] sc_val;
  logic               sc_sat;
  logic [ITW-1:0]     it_next;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  fdu_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b), .add_i(mul_add),
    .done_o(mul_done), .prod_o(mul_prod), .neg_o(mul_neg), .mulq_o(mulq)
  );

  fdu_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .n_i(r2_q), .done_o(sqrt_done),
    .root_o(sqrt_root)
  );

  fdu_atan u_atan (
    .clk_i, .rst_ni, .start_i(atan_start), .r_i(r_q), .done_o(atan_done),
    .theta_o(atan_theta)
  );

  fdu_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(mul_prod), .den_i(r_q),
    .done_o(div_done), .quo_o(div_quo), .big_o(div_big)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_K; i++) coeff_q[i] <= '0;
      max_iter_q <= 6'd10;
      step_thr_q <= 31'd17;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_K1:          coeff_q[0] <= cfg_wdata_i;
        CFG_K2:          coeff_q[1] <= cfg_wdata_i;
        CFG_K3:          coeff_q[2] <= cfg_wdata_i;
        CFG_K4:          coeff_q[3] <= cfg_wdata_i;
        CFG_K5:          coeff_q[4] <= cfg_wdata_i;
        CFG_MAX_ITER:    max_iter_q <= cfg_wdata_i[5:0];
        CFG_STEP_THRESH: step_thr_q <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // unit starts and multiplier operand selection
  always_comb begin
    mul_start  = 1'b0;
    sqrt_start = go_q && (state_q == S_SQRT);
    atan_start = go_q && (state_q == S_ATAN);
    div_start  = mul_done && (state_q == S_SCX || state_q == S_SCY);
    mul_a      = '0;
    mul_b      = '0;
    mul_add    = '0;
    unique case (state_q)
      S_THR: begin
        mul_start = go_q;
        mul_a     = $signed({33'b0, step_thr_q});
        mul_b     = $signed({33'b0, step_thr_q});
      end
      S_R2A: begin
        mul_start = go_q;
        mul_a     = 64'(ox_q);
        mul_b     = 64'(ox_q);
      end
      S_R2B: begin
        mul_start = go_q;
        mul_a     = 64'(oy_q);
        mul_b     = 64'(oy_q);
        mul_add   = r2_q;
      end
      S_T2: begin
        mul_start = go_q;
        mul_a     = 64'(theta_q);
        mul_b     = 64'(theta_q);
        mul_add   = HALF;
      end
      S_KMUL: begin
        mul_start = go_q;
        mul_a     = 64'(coeff_q[k_q]);
        mul_b     = tp_q;
        mul_add   = HALF;
      end
      S_TPMUL: begin
        mul_start = go_q;
        mul_a     = tp_q;
        mul_b     = t2_q;
        mul_add   = HALF;
      end
      S_TD: begin
        mul_start = go_q;
        mul_a     = 64'(theta_q);
        mul_b     = poly_q;
        mul_add   = HALF;
      end
      S_SCX: begin
        mul_start = go_q;
        mul_a     = td_q;
        mul_b     = 64'(ox_q);
        mul_add   = {33'b0, r_q[31:1]};
      end
      S_SCY: begin
        mul_start = go_q;
        mul_a     = td_q;
        mul_b     = 64'(oy_q);
        mul_add   = {33'b0, r_q[31:1]};
      end
      S_FX2: begin
        mul_start = go_q;
        mul_a     = 64'(fx_q);
        mul_b     = 64'(fx_q);
      end
      S_FY2: begin
        mul_start = go_q;
        mul_a     = 64'(fy_q);
        mul_b     = 64'(fy_q);
        mul_add   = fsq_q;
      end
      default: ;
    endcase
  end

  // saturate the scaled coordinate to 32 bits
  always_comb begin
    if (neg_q) begin
      if (div_big || div_quo > 41'h0_8000_0000) begin
        sc_val = 32'sh8000_0000;
        sc_sat = 1'b1;
      end else begin
        sc_val = -$signed(div_quo[31:0]);
        sc_sat = 1'b0;
      end
    end else begin
      if (div_big || div_quo > 41'h0_7FFF_FFFF) begin
        sc_val = 32'sh7FFF_FFFF;
        sc_sat = 1'b1;
      end else begin
        sc_val = $signed(div_quo[31:0]);
        sc_sat = 1'b0;
      end
    end
  end

  // fixed point update and range checks
  assign fx_c     = 34'(dx_q) - 34'(px_q);
  assign fy_c     = 34'(dy_q) - 34'(py_q);
  assign gx_c     = 34'(ox_q) + fx_c;
  assign gy_c     = 34'(oy_q) + fy_c;
  assign gx_ok    = (gx_c[33:31] == 3'b000) || (gx_c[33:31] == 3'b111);
  assign gy_ok    = (gy_c[33:31] == 3'b000) || (gy_c[33:31] == 3'b111);
  assign fx_small = ((fx_c[33:31] == 3'b000) || (fx_c[33:31] == 3'b111))
                    && (fx_c != -34'sh0_8000_0000);
  assign fy_small = ((fy_c[33:31] == 3'b000) || (fy_c[33:31] == 3'b111))
                    && (fy_c != -34'sh0_8000_0000);
  assign it_next  = it_q + ITW'(1);
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    go_d    = 1'b0;
    cmd_d   = cmd_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    px_d    = px_q;
    py_d    = py_q;
    sat_d   = sat_q;
    neg_d   = neg_q;
    r2_d    = r2_q;
    thr2_d  = thr2_q;
    fsq_d   = fsq_q;
    r_d     = r_q;
    theta_d = theta_q;
    t2_d    = t2_q;
    tp_d    = tp_q;
    poly_d  = poly_q;
    td_d    = td_q;
    k_d     = k_q;
    fx_d    = fx_q;
    fy_d    = fy_q;
    it_d    = it_q;
    n_d     = n_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d = in_data_i.command;
          dx_d  = in_data_i.x_in;
          dy_d  = in_data_i.y_in;
          ox_d  = in_data_i.x_in;
          oy_d  = in_data_i.y_in;
          it_d  = '0;
          if (32'(max_iter_q) > 32'(MAX_ITER_BOUND)) n_d = ITW'(MAX_ITER_BOUND);
          else                                        n_d = ITW'(max_iter_q);
          go_d = 1'b1;
          if (in_data_i.command == CMD_DISTORT) begin
            state_d = S_R2A;
          end else if (max_iter_q == 6'd0) begin
            res_d   = '{x_out: in_data_i.x_in, y_out: in_data_i.y_in, status: STATUS_OK};
            go_d    = 1'b0;
            state_d = S_OUT;
          end else begin
            state_d = S_THR;
          end
        end
      end
      S_THR: if (mul_done) begin
        thr2_d  = mul_prod[63:0];
        go_d    = 1'b1;
        state_d = S_R2A;
      end
      S_R2A: if (mul_done) begin
        r2_d    = mul_prod[63:0];
        go_d    = 1'b1;
        state_d = S_R2B;
      end
      S_R2B: if (mul_done) begin
        r2_d = mul_prod[63:0];
        if (mul_prod[63:0] == 64'd0) begin
          // zero radius passes the point through
          px_d    = ox_q;
          py_d    = oy_q;
          sat_d   = 1'b0;
          state_d = S_DRET;
        end else begin
          go_d    = 1'b1;
          state_d = S_SQRT;
        end
      end
      S_SQRT: if (sqrt_done) begin
        r_d     = sqrt_root;
        go_d    = 1'b1;
        state_d = S_ATAN;
      end
      S_ATAN: if (atan_done) begin
        theta_d = atan_theta;
        go_d    = 1'b1;
        state_d = S_T2;
      end
      S_T2: if (mul_done) begin
        t2_d    = mulq;
        tp_d    = mulq;
        poly_d  = ONE;
        k_d     = '0;
        go_d    = 1'b1;
        state_d = S_KMUL;
      end
      S_KMUL: if (mul_done) begin
        poly_d = poly_q + mulq;
        go_d   = 1'b1;
        if (k_q == 3'(NK - 1)) state_d = S_TD;
        else                   state_d = S_TPMUL;
      end
      S_TPMUL: if (mul_done) begin
        tp_d    = mulq;
        k_d     = k_q + 3'd1;
        go_d    = 1'b1;
        state_d = S_KMUL;
      end
      S_TD: if (mul_done) begin
        td_d    = mulq;
        go_d    = 1'b1;
        state_d = S_SCX;
      end
      S_SCX: if (mul_done) begin
        neg_d   = mul_neg;
        state_d = S_DIVX;
      end
      S_DIVX: if (div_done) begin
        px_d    = sc_val;
        sat_d   = sc_sat;
        go_d    = 1'b1;
        state_d = S_SCY;
      end
      S_SCY: if (mul_done) begin
        neg_d   = mul_neg;
        state_d = S_DIVY;
      end
      S_DIVY: if (div_done) begin
        py_d    = sc_val;
        sat_d   = sat_q | sc_sat;
        state_d = S_DRET;
      end
      S_DRET: begin
        if (cmd_q == CMD_DISTORT) begin
          res_d   = '{x_out: px_q, y_out: py_q, status: sat_q};
          state_d = S_OUT;
        end else if (sat_q || !gx_ok || !gy_ok) begin
          res_d   = '{x_out: ox_q, y_out: oy_q, status: STATUS_DIVERGED};
          state_d = S_OUT;
        end else begin
          ox_d = gx_c[31:0];
          oy_d = gy_c[31:0];
          fx_d = fx_c;
          fy_d = fy_c;
          if (fx_small && fy_small) begin
            go_d    = 1'b1;
            state_d = S_FX2;
          end else if (it_next == n_q) begin
            res_d   = '{x_out: gx_c[31:0], y_out: gy_c[31:0], status: STATUS_OK};
            state_d = S_OUT;
          end else begin
            it_d    = it_next;
            go_d    = 1'b1;
            state_d = S_R2A;
          end
        end
      end
      S_FX2: if (mul_done) begin
        fsq_d   = mul_prod[63:0];
        go_d    = 1'b1;
        state_d = S_FY2;
      end
      S_FY2: if (mul_done) begin
        // converged, or out of iterations
        if (mul_prod[63:0] < thr2_q || it_next == n_q) begin
          res_d   = '{x_out: ox_q, y_out: oy_q, status: STATUS_OK};
          state_d = S_OUT;
        end else begin
          it_d    = it_next;
          go_d    = 1'b1;
          state_d = S_R2A;
        end
      end
      S_OUT: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      it_q        <= '0;
      n_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      it_q    <= it_d;
      n_q     <= n_d;
      k_q     <= k_d;
      if (out_load)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    px_q    <= px_d;
    py_q    <= py_d;
    sat_q   <= sat_d;
    neg_q   <= neg_d;
    r2_q    <= r2_d;
    thr2_q  <= thr2_d;
    fsq_q   <= fsq_d;
    r_q     <= r_d;
    theta_q <= theta_d;
    t2_q    <= t2_d;
    tp_q    <= tp_d;
    poly_q  <= poly_d;
    td_q    <= td_d;
    fx_q    <= fx_d;
    fy_q    <= fy_d;
    res_q   <= res_d;
    if (out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (it_q <= n_q))
    else $error("iteration count beyond bound");

  a_mul_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_THR || state_q == S_R2A || state_q == S_R2B ||
                  state_q == S_T2 || state_q == S_KMUL || state_q == S_TPMUL ||
                  state_q == S_TD || state_q == S_SCX || state_q == S_SCY ||
                  state_q == S_FX2 || state_q == S_FY2))
    else $error("multiplier result outside a multiply step");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVX || state_q == S_DIVY))
    else $error("divider result outside a scaling step");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (r_q != 32'd0))
    else $error("scaling started with zero radius");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the fisheye distort/undistort block.
// Depends on fdu_pkg and fisheye_distort_undistort; a built-in fixed point model
// predicts each result, and a scoreboard compares every output transfer with it.
`timescale 1ns / 1ps
module testbench;
  import fdu_pkg::*;

  localparam int ITER_CAP = 32;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam longint unsigned SAT_MAG = 64'd1 << 62;

  // expected results and the fixed point model of the distortion
  class fisheye_sb;
    longint coeff[NUM_K];
    int unsigned iter_limit;
    longint unsigned thresh;
    out_t expected_q[$];
    int errors;
    longint unsigned angle_tab[CORDIC_STEPS] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
      127, 63, 31, 15, 8, 4, 2, 1};

    function new();
      for (int i = 0; i < NUM_K; i++) coeff[i] = 0;
      iter_limit = 10;
      thresh = 17;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      if (idx < NUM_K) coeff[idx] = longint'($signed(d));
      else if (idx == CFG_MAX_ITER) iter_limit = 32'(d[5:0]);
      else if (idx == CFG_STEP_THRESH) thresh = 64'(d[30:0]);
    endfunction

    function longint unsigned umag(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // q product, magnitude rounded half up and saturated
    function longint qmul(longint a, longint b);
      logic [127:0] p;
      longint unsigned m;
      p = {64'd0, umag(a)} * {64'd0, umag(b)};
      p = p + (128'd1 << (FRAC_BITS - 1));
      if (p[127:64+FRAC_BITS] != 0) m = SAT_MAG;
      else m = p[64+FRAC_BITS-1:FRAC_BITS];
      if (m > SAT_MAG) m = SAT_MAG;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // cordic vectoring of (1, r), angle in q30 then rounded to q
    function longint arctan_q(longint r);
      longint cx, cy, z, nx, ny;
      int s;
      cx = 64'sd1 <<< FRAC_BITS;
      cy = r;
      z = 0;
      s = ANGLE_FRAC - FRAC_BITS;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (cy >= 0) begin
          nx = cx + (cy >>> i);
          ny = cy - (cx >>> i);
          z = z + longint'(angle_tab[i]);
        end else begin
          nx = cx - (cy >>> i);
          ny = cy + (cx >>> i);
          z = z - longint'(angle_tab[i]);
        end
        cx = nx;
        cy = ny;
      end
      if (s == 0) return z;
      return (z + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // round(td * c / r) with 32 bit saturation
    function longint scale_coord(longint td, longint c, longint unsigned r, inout bit sat);
      logic [127:0] num, q;
      bit neg;
      neg = (td < 0) != (c < 0);
      num = {64'd0, umag(td)} * {64'd0, umag(c)} + {64'd0, r >> 1};
      q = num / {64'd0, r};
      if (neg) begin
        if (q > 128'h8000_0000) begin
          sat = 1;
          return -64'sd2147483648;
        end
        return -longint'(q[63:0]);
      end
      if (q > 128'h7FFF_FFFF) begin
        sat = 1;
        return 64'sd2147483647;
      end
      return longint'(q[63:0]);
    endfunction

    function bit distort_pt(longint x, longint y, output longint ox, output longint oy);
      longint unsigned r2, r;
      longint theta, t2, tp, poly, td;
      bit sat;
      sat = 0;
      r2 = 64'(x * x) + 64'(y * y);
      if (r2 == 0) begin
        ox = x;
        oy = y;
        return 0;
      end
      r = root_floor(r2);
      theta = arctan_q(longint'(r));
      t2 = qmul(theta, theta);
      tp = t2;
      poly = 64'sd1 <<< FRAC_BITS;
      for (int i = 0; i < NUM_K; i++) begin
        poly = poly + qmul(coeff[i], tp);
        tp = qmul(tp, t2);
      end
      td = qmul(theta, poly);
      ox = scale_coord(td, x, r, sat);
      oy = scale_coord(td, y, r, sat);
      return sat;
    endfunction

    function bit fits32(longint v);
      return v >= -64'sd2147483648 && v <= 64'sd2147483647;
    endfunction

    // work out the result of one accepted point
    function void note_point(in_t p);
      longint dx, dy, ox, oy, px, py, fx, fy, gx, gy;
      longint unsigned ax, ay, thr2;
      int unsigned n;
      bit st, sat;
      out_t e;
      dx = longint'(p.x_in);
      dy = longint'(p.y_in);
      st = STATUS_OK;
      if (p.command == CMD_DISTORT) begin
        if (distort_pt(dx, dy, ox, oy)) st = STATUS_DIVERGED;
      end else begin
        n = (iter_limit > ITER_CAP) ? ITER_CAP : iter_limit;
        thr2 = thresh * thresh;
        ox = dx;
        oy = dy;
        for (int unsigned it = 0; it < n; it++) begin
          sat = distort_pt(ox, oy, px, py);
          fx = dx - px;
          fy = dy - py;
          gx = ox + fx;
          gy = oy + fy;
          if (sat || !fits32(gx) || !fits32(gy)) begin
            st = STATUS_DIVERGED;
            break;
          end
          ox = gx;
          oy = gy;
          ax = umag(fx);
          ay = umag(fy);
          if (ax < 64'h8000_0000 && ay < 64'h8000_0000 && ax * ax + ay * ay < thr2) break;
        end
      end
      e.x_out = ox[31:0];
      e.y_out = oy[31:0];
      e.status = st;
      expected_q.push_back(e);
    endfunction

    function void check_point(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        $error("result with no point pending: %h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.x_out !== e.x_out) begin
        $error("x_out expected %0d actual %0d", e.x_out, got.x_out);
        errors++;
      end
      if (got.y_out !== e.y_out) begin
        $error("y_out expected %0d actual %0d", e.y_out, got.y_out);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, cfg_we_i;
  in_t in_data_i;
  out_t out_data_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  fisheye_sb sb = new();
  int in_idle_pct = 25;
  int out_idle_pct = 25;
  bit hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  fisheye_distort_undistort uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // receiver stall, with a single long hold-off
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_point(out_data_o);
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one point transfer, with a random gap before it
  task automatic send_point(input logic cmd, input logic [31:0] x, input logic [31:0] y);
    in_t p;
    p.command = cmd;
    p.x_in = x;
    p.y_in = y;
    @(negedge clk_i);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i = 1'b1;
    in_data_i = p;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_point(p);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [31:0] k1, input logic [31:0] k2,
                            input logic [31:0] k3, input logic [31:0] k4,
                            input logic [31:0] k5, input logic [31:0] iters,
                            input logic [31:0] thr);
    logic [31:0] vals[7];
    logic [CFG_IDX_W-1:0] idx[7];
    vals = '{k1, k2, k3, k4, k5, iters, thr};
    idx = '{CFG_K1, CFG_K2, CFG_K3, CFG_K4, CFG_K5, CFG_MAX_ITER, CFG_STEP_THRESH};
    for (int i = 0; i < 7; i++) begin
      @(negedge clk_i);
      cfg_we_i = 1'b1;
      cfg_idx_i = idx[i];
      cfg_wdata_i = vals[i];
      sb.set_reg(idx[i], vals[i]);
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return $urandom();
      2: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(9))
      0, 1: return $urandom();
      2, 3: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      default: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_thresh();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return 32'd17;
      2: return $urandom_range(0, 65536);
      default: return $urandom();
    endcase
  endfunction

  // stimulus
  initial begin
    int n_items;
    logic [31:0] iters;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, zero radius and coordinate extremes
    send_point(CMD_DISTORT, 32'd0, 32'd0);
    send_point(CMD_UNDISTORT, 32'd0, 32'd0);
    send_point(CMD_DISTORT, 32'h0100_0000, 32'd0);
    send_point(CMD_DISTORT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(CMD_DISTORT, 32'h8000_0000, 32'h8000_0000);
    send_point(CMD_UNDISTORT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(CMD_UNDISTORT, 32'h7FFF_FFFF, 32'd0);
    send_point(CMD_DISTORT, 32'd1, 32'd0);
    send_point(CMD_DISTORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    // huge coefficients: saturation and divergence, iteration count above the bound
    write_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'd63, 32'd0);
    send_point(CMD_DISTORT, 32'h0100_0000, 32'h0100_0000);
    send_point(CMD_UNDISTORT, 32'h0080_0000, 32'h0080_0000);
    send_point(CMD_DISTORT, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    // most negative coefficients, zero iterations, widest threshold
    write_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'd0, 32'h7FFF_FFFF);
    send_point(CMD_UNDISTORT, 32'h004C_CCCD, 32'hFFCC_CCCD);
    send_point(CMD_DISTORT, 32'h0200_0000, 32'hFD00_0000);
    drain();
    // realistic lens, full iteration count without convergence
    write_regs(32'hFFF3_3333, 32'h0004_0000, 32'hFFFF_0000, 32'h0000_4000,
               32'h0000_1000, 32'd32, 32'd0);
    send_point(CMD_UNDISTORT, 32'h0080_0000, 32'hFF80_0000);
    send_point(CMD_UNDISTORT, 32'h0140_0000, 32'h0010_0000);
    send_point(CMD_DISTORT, 32'h0140_0000, 32'h0010_0000);
    drain();
    // converges on the first step
    write_regs(32'hFFF3_3333, 32'h0004_0000, 32'hFFFF_0000, 32'h0000_4000,
               32'h0000_1000, 32'd5, 32'h7FFF_FFFF);
    send_point(CMD_UNDISTORT, 32'h0080_0000, 32'h0030_0000);
    send_point(CMD_UNDISTORT, 32'hFF00_0000, 32'h0000_0000);
    drain();

    // random phases, each with its own settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        2: iters = 32'd0;
        3: iters = 32'd63;
        4: iters = 32'd32;
        default: iters = $urandom_range(1, 6);
      endcase
      write_regs(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(),
                 iters, rand_thresh());
      in_idle_pct = (ph == 0) ? 0 : 25;
      out_idle_pct = (ph == 0) ? 0 : 25;
      n_items = (ph == 3 || ph == 4) ? 40 : 280;
      for (int i = 0; i < n_items; i++) begin
        if (ph == 1 && i == 50) hold_req = 1;
        if (ph == 1 && i == 150) drain();
        send_point(1'($urandom_range(1)), rand_coord(), rand_coord());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
